@@ rtl/slh64_pkg.sv @@
`timescale 1ns / 1ps
// Package for the 64-bit long-key hash block: state sizes, seed constants,
// queue entry types and the engine state encoding. No dependencies.
package slh64_pkg;

   // Number of 64-bit mixing words and the index width that addresses them.
   localparam int unsigned NUM_WORDS   = 12;
   localparam int unsigned IDX_W       = 4;
   localparam int unsigned BLOCK_BYTES = 96;
   localparam int unsigned END_ROUNDS  = 3;
   localparam int unsigned WORD_BYTES  = 8;

   // Seed constants, repeated every three mixing words.
   localparam logic [63:0] SEED_A = 64'h9e3779b99e3779b9;
   localparam logic [63:0] SEED_B = 64'hdead10ccdead10cc;
   localparam logic [63:0] SEED_C = 64'hdeadbeefdeadbeef;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [63:0] word_type;
   typedef word_type [NUM_WORDS-1:0] mix_state_type;

   // One classified request as it waits for the engine.
   typedef struct packed {
      word_type   key_word;
      logic [3:0] byte_count;
      logic       last_word;
   } queue_entry_type;

   // Head of the queue as the engine sees it.
   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

   // Engine sequencer states.
   typedef enum logic [1:0] {
      ST_MIX,
      ST_PAD,
      ST_END,
      ST_OUT
   } back_state_type;

endpackage

@@ rtl/slh64_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// No dependencies.
interface slh64_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] key_word;
   logic [3:0]  byte_count;
   logic        last_word;

   modport source (output valid, key_word, byte_count, last_word, input ready);
   modport sink   (input valid, key_word, byte_count, last_word, output ready);
endinterface

interface slh64_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;
   logic [31:0] hash_low;

   modport source (output valid, hash_value, hash_low, input ready);
   modport sink   (input valid, hash_value, hash_low, output ready);
endinterface

@@ rtl/slh64_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts requests, clamps the byte count and masks unused bytes
// of the final word. Depends on slh64_pkg and slh64_req_if.
module slh64_front (
   slh64_req_if.sink                 req,
   input  logic                      queue_full,
   output logic                      push,
   output slh64_pkg::queue_entry_type push_entry
);

   logic [3:0]             count_clamped;
   slh64_pkg::word_type    byte_mask;

   // A request is taken whenever the queue has room.
   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   // Words that are not the last always carry eight bytes; counts above eight clamp.
   always_comb begin
      if (!req.last_word || req.byte_count > 4'(slh64_pkg::WORD_BYTES)) begin
         count_clamped = 4'(slh64_pkg::WORD_BYTES);
      end else begin
         count_clamped = req.byte_count;
      end
   end

   // Keep only the valid low bytes.
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         byte_mask[8*b +: 8] = (4'(b) < count_clamped) ? 8'hff : 8'h00;
      end
   end

   always_comb begin
      push_entry.key_word   = req.key_word & byte_mask;
      push_entry.byte_count = count_clamped;
      push_entry.last_word  = req.last_word;
   end

endmodule

@@ rtl/slh64_queue.sv @@
`timescale 1ns / 1ps
// Short first-in first-out queue between the front end and the engine.
// Depends on slh64_pkg.
module slh64_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  slh64_pkg::queue_entry_type push_entry,
   output logic                       full,
   input  logic                       pop,
   output slh64_pkg::queue_head_type  head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   slh64_pkg::queue_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (fill_ff == CNT_W'(DEPTH));
   assign head.valid = (fill_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/slh64_back.sv @@
`timescale 1ns / 1ps
// Engine: applies one mix line per word, pads the final block, runs the end
// rounds one line per cycle and holds the result. Depends on slh64_pkg and slh64_rsp_if.
module slh64_back (
   input  logic                      clock,
   input  logic                      reset,
   input  slh64_pkg::queue_head_type head,
   output logic                      pop,
   slh64_rsp_if.source               rsp
);

   localparam slh64_pkg::idx_type LAST_IDX = slh64_pkg::IDX_W'(slh64_pkg::NUM_WORDS - 1);

   // Index offset modulo the number of mixing words.
   function automatic slh64_pkg::idx_type wrap_idx(slh64_pkg::idx_type a,
                                                   slh64_pkg::idx_type k);
      logic [slh64_pkg::IDX_W:0] s;
      s = {1'b0, a} + {1'b0, k};
      if (s >= (slh64_pkg::IDX_W + 1)'(slh64_pkg::NUM_WORDS)) begin
         s = s - (slh64_pkg::IDX_W + 1)'(slh64_pkg::NUM_WORDS);
      end
      return s[slh64_pkg::IDX_W-1:0];
   endfunction

   function automatic slh64_pkg::word_type rotl(slh64_pkg::word_type x, logic [5:0] k);
      logic [127:0] t;
      t = {x, x} << k;
      return t[127:64];
   endfunction

   function automatic logic [5:0] mix_rot(slh64_pkg::idx_type a);
      logic [5:0] r;
      unique case (a)
         4'd0:    r = 6'd11;
         4'd1:    r = 6'd32;
         4'd2:    r = 6'd43;
         4'd3:    r = 6'd31;
         4'd4:    r = 6'd17;
         4'd5:    r = 6'd28;
         4'd6:    r = 6'd39;
         4'd7:    r = 6'd57;
         4'd8:    r = 6'd55;
         4'd9:    r = 6'd54;
         4'd10:   r = 6'd22;
         4'd11:   r = 6'd46;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] end_rot(slh64_pkg::idx_type j);
      logic [5:0] r;
      unique case (j)
         4'd0:    r = 6'd44;
         4'd1:    r = 6'd15;
         4'd2:    r = 6'd34;
         4'd3:    r = 6'd21;
         4'd4:    r = 6'd38;
         4'd5:    r = 6'd33;
         4'd6:    r = 6'd10;
         4'd7:    r = 6'd13;
         4'd8:    r = 6'd38;
         4'd9:    r = 6'd53;
         4'd10:   r = 6'd42;
         4'd11:   r = 6'd54;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   function automatic slh64_pkg::mix_state_type seed_state();
      slh64_pkg::mix_state_type s;
      for (int i = 0; i < slh64_pkg::NUM_WORDS; i++) begin
         s[i] = (i % 3 == 0) ? slh64_pkg::SEED_A :
                (i % 3 == 1) ? slh64_pkg::SEED_B : slh64_pkg::SEED_C;
      end
      return s;
   endfunction

   // One line of the mix round at word position a with data d.
   function automatic slh64_pkg::mix_state_type mix_line(slh64_pkg::mix_state_type s,
                                                        slh64_pkg::idx_type a,
                                                        slh64_pkg::word_type d);
      slh64_pkg::mix_state_type r;
      slh64_pkg::word_type      sa;
      r  = s;
      sa = s[a] + d;
      r[wrap_idx(a, 4'd2)]  = s[wrap_idx(a, 4'd2)] ^ s[wrap_idx(a, 4'd10)];
      r[wrap_idx(a, 4'd11)] = (s[wrap_idx(a, 4'd11)] ^ sa) + s[wrap_idx(a, 4'd1)];
      r[a]                  = rotl(sa, mix_rot(a));
      return r;
   endfunction

   // One step j of an end round.
   function automatic slh64_pkg::mix_state_type end_step(slh64_pkg::mix_state_type s,
                                                        slh64_pkg::idx_type j);
      slh64_pkg::mix_state_type r;
      slh64_pkg::word_type      hp;
      slh64_pkg::idx_type       p;
      slh64_pkg::idx_type       q;
      slh64_pkg::idx_type       t;
      r  = s;
      p  = wrap_idx(j, 4'd11);
      q  = wrap_idx(j, 4'd1);
      t  = wrap_idx(j, 4'd2);
      hp = s[p] + s[q];
      r[p] = hp;
      r[t] = s[t] ^ hp;
      r[q] = rotl(s[q], end_rot(j));
      return r;
   endfunction

   slh64_pkg::back_state_type state_ff, state_in;
   slh64_pkg::mix_state_type  mix_ff, mix_in;
   slh64_pkg::idx_type        line_ff, line_in;
   logic [1:0]                round_ff, round_in;
   logic [6:0]                rem_ff, rem_in;
   logic                      out_valid_ff, out_valid_in;
   slh64_pkg::word_type       hash_ff, hash_in;
   logic [6:0]                rem_calc;
   logic                      full_block;
   slh64_pkg::word_type       data_word;
   logic                      load_out;

   assign rsp.valid      = out_valid_ff;
   assign rsp.hash_value = hash_ff;
   assign rsp.hash_low   = hash_ff[31:0];

   // Bytes in the final block, counted up to and including this word.
   assign rem_calc   = {line_ff, 3'b000} + {3'b000, head.entry.byte_count};
   assign full_block = (rem_calc >= 7'(slh64_pkg::BLOCK_BYTES));

   // Sequencer: next state, mixing state and output register.
   always_comb begin
      state_in  = state_ff;
      mix_in    = mix_ff;
      line_in   = line_ff;
      round_in  = round_ff;
      rem_in    = rem_ff;
      pop       = 1'b0;
      load_out  = 1'b0;
      data_word = '0;
      unique case (state_ff)
         slh64_pkg::ST_MIX: begin
            if (head.valid) begin
               pop = 1'b1;
               data_word = head.entry.key_word;
               if (!head.entry.last_word) begin
                  mix_in  = mix_line(mix_ff, line_ff, data_word);
                  line_in = (line_ff == LAST_IDX) ? '0 : line_ff + 1'b1;
               end else begin
                  // The remainder count lands in byte 95 unless the block is full.
                  if (line_ff == LAST_IDX && !full_block) begin
                     data_word = data_word | {1'b0, rem_calc, 56'd0};
                  end
                  mix_in   = mix_line(mix_ff, line_ff, data_word);
                  rem_in   = full_block ? 7'd0 : rem_calc;
                  round_in = '0;
                  if (line_ff == LAST_IDX) begin
                     line_in  = '0;
                     state_in = full_block ? slh64_pkg::ST_PAD : slh64_pkg::ST_END;
                  end else begin
                     line_in  = line_ff + 1'b1;
                     state_in = slh64_pkg::ST_PAD;
                  end
               end
            end
         end
         slh64_pkg::ST_PAD: begin
            if (line_ff == LAST_IDX) begin
               data_word = {1'b0, rem_ff, 56'd0};
            end
            mix_in = mix_line(mix_ff, line_ff, data_word);
            if (line_ff == LAST_IDX) begin
               line_in  = '0;
               state_in = slh64_pkg::ST_END;
            end else begin
               line_in = line_ff + 1'b1;
            end
         end
         slh64_pkg::ST_END: begin
            mix_in = end_step(mix_ff, line_ff);
            if (line_ff == LAST_IDX) begin
               line_in = '0;
               if (round_ff == 2'(slh64_pkg::END_ROUNDS - 1)) begin
                  state_in = slh64_pkg::ST_OUT;
               end else begin
                  round_in = round_ff + 1'b1;
               end
            end else begin
               line_in = line_ff + 1'b1;
            end
         end
         slh64_pkg::ST_OUT: begin
            // Hand the hash over once the output register is free, then reseed.
            if (!out_valid_ff || rsp.ready) begin
               load_out = 1'b1;
               mix_in   = seed_state();
               line_in  = '0;
               state_in = slh64_pkg::ST_MIX;
            end
         end
         default: begin
            state_in = slh64_pkg::ST_MIX;
         end
      endcase
   end

   // Output register bookkeeping.
   always_comb begin
      hash_in      = load_out ? mix_ff[0] : hash_ff;
      out_valid_in = load_out ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slh64_pkg::ST_MIX;
         mix_ff       <= seed_state();
         line_ff      <= '0;
         round_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mix_ff       <= mix_in;
         line_ff      <= line_in;
         round_ff     <= round_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      hash_ff <= hash_in;
   end

endmodule

@@ rtl/spooky_long_hash64.sv @@
`timescale 1ns / 1ps
// Long-key 64-bit hash. Each key word is registered in the queue and mixed
// when the engine pops it, so full words flow at one per cycle while it mixes.
// A final word at block word L is followed by padding of block words L+1 to 11
// (a whole padding block if the block is full), the end rounds and the output.
// Reset (synchronous) reseeds the mixing words, empties the queue and the result.
module spooky_long_hash64 #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   slh64_req_if.sink   req,
   slh64_rsp_if.source rsp
);

   logic                       push;
   slh64_pkg::queue_entry_type push_entry;
   logic                       queue_full;
   logic                       pop;
   slh64_pkg::queue_head_type  head;

   // Request classification.
   slh64_front u_front (
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue.
   slh64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   // Mixing engine and result register.
   slh64_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

@@ rtl/slh64_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the long-key hash block, bound to its top level.
// Depends on spooky_long_hash64 and its channel interfaces.
module slh64_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_word,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] hash_value,
   input logic [31:0] hash_low
);

   logic [7:0] pending_ff, pending_in;
   logic       last_taken;
   logic       rsp_taken;

   // Keys whose final word was accepted but whose hash is not yet delivered.
   assign last_taken = req_valid && req_ready && req_last_word;
   assign rsp_taken  = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (last_taken && !rsp_taken) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_taken && !last_taken) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled response keeps its hash.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(hash_value))
      else $error("response dropped or changed while stalled");

   // The short form is the low half of the full hash.
   a_low_half: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> hash_low == hash_value[31:0])
      else $error("hash_low does not match hash_value");

   // Reset clears any pending response.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Every response belongs to a key whose final word was accepted.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("response without a completed key");

endmodule

bind spooky_long_hash64 slh64_checker u_slh64_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_last_word (req.last_word),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .hash_value    (rsp.hash_value),
   .hash_low      (rsp.hash_low)
);
